// ===== sv/ise_pkg.sv =====
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types and constants of the interval set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ise_pkg;

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_QUERY  = 3'd2;
	localparam logic [2:0] CMD_SET    = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic signed [63:0] BOUND_MAX = 64'sh7fff_ffff_ffff_ffff;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CLASS,
		S_EVAL
	} state_t;

	typedef enum logic [2:0] {
		C_HOLD,
		C_CLASS,
		C_SHIFT_L,
		C_INSERT,
		C_MERGE,
		C_SPLIT,
		C_SET
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic             is_add;
		logic             trim_en;
		logic signed [63:0] rlo;
		logic signed [63:0] rhi;
	} cell_ctl_t;

	typedef struct packed {
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		logic             mrg;
		logic             del;
		logic             split;
		logic             abv;
		logic             below;
	} cell_nb_t;

	function automatic logic signed [63:0] sat_inc(input logic signed [63:0] v);
		sat_inc = (v == BOUND_MAX) ? v : v + 64'sd1;
	endfunction

endpackage

`default_nettype wire

// ===== sv/ise_in_if.sv =====
// ----------------------------------------------------------------------------
// ise_in_if
// Command channel of the interval set engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ise_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [63:0] range_low;
	logic signed [63:0] range_high;
	logic [4:0]         entry_index;

	modport source (output valid, cmd, range_low, range_high, entry_index, input ready);
	modport sink (input valid, cmd, range_low, range_high, entry_index, output ready);
endinterface

`default_nettype wire

// ===== sv/ise_out_if.sv =====
// ----------------------------------------------------------------------------
// ise_out_if
// Result channel of the interval set engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ise_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               covered;
	logic signed [63:0] entry_low;
	logic signed [63:0] entry_high;
	logic [5:0]         entry_total;

	modport source (output valid, status, covered, entry_low, entry_high, entry_total,
		input ready);
	modport sink (input valid, status, covered, entry_low, entry_high, entry_total,
		output ready);
endinterface

`default_nettype wire

// ===== sv/interval_set_engine.sv =====
// result: a command passes S_CLASS and S_EVAL before the result is registered, and
// S_EVAL repeats for each entry merged away by add or dropped by remove
// throughput: one command at a time, next command taken once the result transfers
// the row of cells classifies all entries at once, then shifts by one slot per cycle
// reset: table empty, no result pending, ready for a command
// ----------------------------------------------------------------------------
// interval_set_engine
// Sorted table of disjoint signed 64-bit ranges kept in a row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_engine import ise_pkg::*; #(
	parameter int MAX_RANGES = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	ise_in_if.sink   in_ch,
	ise_out_if.source out_ch
);

	localparam int CW = $clog2(MAX_RANGES + 1);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [2:0] cmd_q;
	logic signed [63:0] rlo_q, rhi_q;
	logic [4:0] idx_q;

	logic ovalid_q;
	logic [1:0] status_q, status_d;
	logic covered_q, covered_d;
	logic signed [63:0] elo_q, ehi_q, rd_lo, rd_hi;

	logic finish, bad, full;
	cell_op_t op;
	cell_ctl_t ctl;

	cell_nb_t nbs [MAX_RANGES];
	cell_nb_t prv_s [MAX_RANGES];
	cell_nb_t nxt_s [MAX_RANGES];
	logic [MAX_RANGES:0] pfx;
	logic [MAX_RANGES-1:0] covs, hits, mrgs, splits;
	logic any_mark, any_mrg, any_split, any_cov;

	assign in_ch.ready = (state_q == S_IDLE) && !ovalid_q;
	assign bad  = (cmd_q <= CMD_SET) && (rhi_q < rlo_q);
	assign full = (count_q == CW'(MAX_RANGES));

	assign ctl.op      = op;
	assign ctl.is_add  = (cmd_q == CMD_ADD);
	assign ctl.trim_en = (cmd_q == CMD_REMOVE) && !bad;
	assign ctl.rlo     = rlo_q;
	assign ctl.rhi     = rhi_q;

	assign pfx[0]    = 1'b0;
	assign any_mark  = pfx[MAX_RANGES];
	assign any_mrg   = |mrgs;
	assign any_split = |splits;
	assign any_cov   = |covs;

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		cell_ctl_t cctl;
		assign cctl.op      = (op == C_SET && i != 0) ? C_HOLD : op;
		assign cctl.is_add  = ctl.is_add;
		assign cctl.trim_en = ctl.trim_en;
		assign cctl.rlo     = ctl.rlo;
		assign cctl.rhi     = ctl.rhi;
		assign mrgs[i]   = nbs[i].mrg;
		assign splits[i] = nbs[i].split;
		if (i == 0) begin : g_first
			assign prv_s[i] = '{lo: '0, hi: '0, mrg: 1'b0, del: 1'b0, split: 1'b0,
				abv: 1'b0, below: 1'b1};
		end else begin : g_mid
			assign prv_s[i] = nbs[i-1];
		end
		if (i == MAX_RANGES - 1) begin : g_last
			assign nxt_s[i] = '0;
		end else begin : g_inner
			assign nxt_s[i] = nbs[i+1];
		end
		ise_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cctl),
			.valid   (32'(count_q) > i),
			.pick    (32'(idx_q) == i),
			.prv     (prv_s[i]),
			.nxt     (nxt_s[i]),
			.pfx_in  (pfx[i]),
			.pfx_out (pfx[i+1]),
			.nb      (nbs[i]),
			.cov     (covs[i]),
			.hit     (hits[i])
		);
	end

	always_comb begin
		rd_lo = '0;
		rd_hi = '0;
		for (int i = 0; i < MAX_RANGES; i++) begin
			if (hits[i]) begin
				rd_lo = rd_lo | nbs[i].lo;
				rd_hi = rd_hi | nbs[i].hi;
			end
		end
	end

	always_comb begin
		op        = C_HOLD;
		count_d   = count_q;
		finish    = 1'b0;
		status_d  = ST_OK;
		covered_d = 1'b0;
		case (state_q)
			S_CLASS: op = C_CLASS;
			S_EVAL: begin
				finish = 1'b1;
				if (bad) begin
					status_d = ST_BAD;
				end else begin
					case (cmd_q)
						CMD_ADD: begin
							if (any_mark) begin
								op      = C_SHIFT_L;
								count_d = count_q - 1'b1;
								finish  = 1'b0;
							end else if (!any_mrg) begin
								if (full) begin
									status_d = ST_FULL;
								end else begin
									op      = C_INSERT;
									count_d = count_q + 1'b1;
								end
							end else begin
								op = C_MERGE;
							end
						end
						CMD_REMOVE: begin
							if (any_split) begin
								if (full) begin
									status_d = ST_FULL;
								end else begin
									op      = C_SPLIT;
									count_d = count_q + 1'b1;
								end
							end else if (any_mark) begin
								op      = C_SHIFT_L;
								count_d = count_q - 1'b1;
								finish  = 1'b0;
							end
						end
						CMD_QUERY: covered_d = any_cov;
						CMD_SET: begin
							op      = C_SET;
							count_d = CW'(1);
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_ch.valid && in_ch.ready) state_d = S_CLASS;
			S_CLASS: state_d = S_EVAL;
			S_EVAL:  if (finish) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (finish)
				ovalid_q <= 1'b1;
			else if (out_ch.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_q <= in_ch.cmd;
			rlo_q <= in_ch.range_low;
			rhi_q <= in_ch.range_high;
			idx_q <= in_ch.entry_index;
		end
		if (finish) begin
			status_q  <= status_d;
			covered_q <= covered_d;
			elo_q     <= (cmd_q == CMD_READ) ? rd_lo : '0;
			ehi_q     <= (cmd_q == CMD_READ) ? rd_hi : '0;
		end
	end

	logic [CW+5:0] total_w;
	assign total_w = {6'd0, count_q};

	assign out_ch.valid       = ovalid_q;
	assign out_ch.status      = status_q;
	assign out_ch.covered     = covered_q;
	assign out_ch.entry_low   = elo_q;
	assign out_ch.entry_high  = ehi_q;
	assign out_ch.entry_total = total_w[5:0];

endmodule

`default_nettype wire

// ===== sv/ise_cell.sv =====
// ----------------------------------------------------------------------------
// ise_cell
// One table slot: holds a range, classifies it against the request and
// shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_cell import ise_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      valid,
	input  logic      pick,
	input  cell_nb_t  prv,
	input  cell_nb_t  nxt,
	input  logic      pfx_in,
	output logic      pfx_out,
	output cell_nb_t  nb,
	output logic      cov,
	output logic      hit
);

	logic signed [63:0] lo_q, hi_q, lo_d, hi_d;
	logic mrg_q, del_q, split_q, abv_q, below_q, cov_q, hit_q;
	logic mrg_d, del_d, split_d, abv_d, below_d, cov_d, hit_d;
	logic mark;
	logic signed [63:0] nu_eh, nu_rh;

	assign mark    = ctl.is_add ? (mrg_q & nxt.mrg) : del_q;
	assign pfx_out = pfx_in | mark;
	assign nu_eh   = sat_inc(hi_q);
	assign nu_rh   = sat_inc(ctl.rhi);

	always_comb begin
		lo_d    = lo_q;
		hi_d    = hi_q;
		mrg_d   = mrg_q;
		del_d   = del_q;
		split_d = split_q;
		abv_d   = abv_q;
		below_d = below_q;
		cov_d   = cov_q;
		hit_d   = hit_q;
		case (ctl.op)
			C_CLASS: begin
				below_d = valid & (nu_eh < ctl.rlo);
				mrg_d   = valid & !(nu_eh < ctl.rlo) & (lo_q <= nu_rh);
				del_d   = valid & (lo_q >= ctl.rlo) & (hi_q <= ctl.rhi);
				split_d = valid & (lo_q < ctl.rlo) & (hi_q > ctl.rhi);
				abv_d   = valid & (lo_q > ctl.rhi);
				cov_d   = valid & (lo_q <= ctl.rlo) & (hi_q >= ctl.rhi);
				hit_d   = valid & pick;
				if (ctl.trim_en && valid) begin
					if (lo_q < ctl.rlo && hi_q >= ctl.rlo && hi_q <= ctl.rhi)
						hi_d = ctl.rlo - 64'sd1;
					if (lo_q >= ctl.rlo && lo_q <= ctl.rhi && hi_q > ctl.rhi)
						lo_d = ctl.rhi + 64'sd1;
				end
			end
			C_SHIFT_L: begin
				if (pfx_in || (mark && !ctl.is_add)) begin
					lo_d  = nxt.lo;
					hi_d  = nxt.hi;
					mrg_d = nxt.mrg;
					del_d = nxt.del;
				end else if (mark) begin
					hi_d = nxt.hi;
				end
			end
			C_INSERT: begin
				if (!below_q) begin
					if (prv.below) begin
						lo_d = ctl.rlo;
						hi_d = ctl.rhi;
					end else begin
						lo_d = prv.lo;
						hi_d = prv.hi;
					end
				end
			end
			C_MERGE: begin
				if (mrg_q) begin
					lo_d = (ctl.rlo < lo_q) ? ctl.rlo : lo_q;
					hi_d = (ctl.rhi > hi_q) ? ctl.rhi : hi_q;
				end
			end
			C_SPLIT: begin
				if (split_q) begin
					hi_d = ctl.rlo - 64'sd1;
				end else if (prv.split) begin
					lo_d = ctl.rhi + 64'sd1;
					hi_d = prv.hi;
				end else if (prv.abv) begin
					lo_d = prv.lo;
					hi_d = prv.hi;
				end
			end
			C_SET: begin
				lo_d = ctl.rlo;
				hi_d = ctl.rhi;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrg_q   <= 1'b0;
			del_q   <= 1'b0;
			split_q <= 1'b0;
			abv_q   <= 1'b0;
			below_q <= 1'b0;
			cov_q   <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			mrg_q   <= mrg_d;
			del_q   <= del_d;
			split_q <= split_d;
			abv_q   <= abv_d;
			below_q <= below_d;
			cov_q   <= cov_d;
			hit_q   <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
	end

	assign nb.lo    = lo_q;
	assign nb.hi    = hi_q;
	assign nb.mrg   = mrg_q;
	assign nb.del   = del_q;
	assign nb.split = split_q;
	assign nb.abv   = abv_q;
	assign nb.below = below_q;
	assign cov      = cov_q;
	assign hit      = hit_q;

endmodule

`default_nettype wire

// ===== sv/ise_checker.sv =====
// ----------------------------------------------------------------------------
// ise_checker
// Port-level checks of the interval set engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_checker import ise_pkg::*; #(
	parameter int MAX_RANGES = 32
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic [5:0] entry_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("command taken while result pending");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result too early");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BAD || status == ST_FULL))
		else $error("bad status code");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && MAX_RANGES < 64 |-> 32'(entry_total) <= MAX_RANGES)
		else $error("entry total beyond table size");

endmodule

bind interval_set_engine ise_checker #(.MAX_RANGES(MAX_RANGES)) u_ise_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.status      (out_ch.status),
	.entry_total (out_ch.entry_total)
);

`default_nettype wire

// ===== dv/interval_set_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_engine_test
// Drives add, remove, query, set and read commands into the interval set
// engine with random gaps on both channels, keeps a sorted range table of
// its own and compares every result field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_engine_test;
	import ise_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		logic [4:0]         idx;
	} command_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               covered;
		logic signed [63:0] elo;
		logic signed [63:0] ehi;
		logic [5:0]         total;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ise_in_if  cmd_ch ();
	ise_out_if reply_ch ();

	interval_set_engine #(.MAX_RANGES(TABLE_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cmd_ch.sink),
		.out_ch (reply_ch.source)
	);

	always #5 clk = ~clk;

	command_t pending_cmds[$];
	reply_t   expected_replies[$];

	logic signed [63:0] tbl_lo[TABLE_DEPTH];
	logic signed [63:0] tbl_hi[TABLE_DEPTH];
	int                 tbl_count = 0;

	int     errors = 0;
	int     sent = 0;
	int     received = 0;
	int     full_seen = 0;
	int     bad_seen = 0;
	int     hits_seen = 0;
	int     send_wait = 0;
	int     recv_wait = 0;
	int     hold_cycles = 0;
	longint unsigned cycle_count = 0;
	bit     stim_done = 0;

	function automatic logic signed [63:0] step_up(input logic signed [63:0] v);
		return (v == BOUND_MAX) ? v : v + 64'sd1;
	endfunction

	// returns status, updates table only on success
	function automatic logic [1:0] commit_list(input logic signed [63:0] nlo[$],
			input logic signed [63:0] nhi[$]);
		if (nlo.size() > TABLE_DEPTH)
			return ST_FULL;
		foreach (nlo[i]) begin
			tbl_lo[i] = nlo[i];
			tbl_hi[i] = nhi[i];
		end
		tbl_count = nlo.size();
		return ST_OK;
	endfunction

	function automatic logic [1:0] table_add(input logic signed [63:0] lo,
			input logic signed [63:0] hi);
		logic signed [63:0] nlo[$];
		logic signed [63:0] nhi[$];
		bit placed;
		placed = 0;
		for (int i = 0; i < tbl_count; i++) begin
			if (step_up(tbl_hi[i]) >= lo && tbl_lo[i] <= step_up(hi)) begin
				if (tbl_lo[i] < lo) lo = tbl_lo[i];
				if (tbl_hi[i] > hi) hi = tbl_hi[i];
			end else begin
				if (tbl_lo[i] > hi && !placed) begin
					nlo.push_back(lo);
					nhi.push_back(hi);
					placed = 1;
				end
				nlo.push_back(tbl_lo[i]);
				nhi.push_back(tbl_hi[i]);
			end
		end
		if (!placed) begin
			nlo.push_back(lo);
			nhi.push_back(hi);
		end
		return commit_list(nlo, nhi);
	endfunction

	function automatic logic [1:0] table_remove(input logic signed [63:0] lo,
			input logic signed [63:0] hi);
		logic signed [63:0] nlo[$];
		logic signed [63:0] nhi[$];
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_hi[i] < lo || tbl_lo[i] > hi) begin
				nlo.push_back(tbl_lo[i]);
				nhi.push_back(tbl_hi[i]);
			end else begin
				if (tbl_lo[i] < lo) begin
					nlo.push_back(tbl_lo[i]);
					nhi.push_back(lo - 64'sd1);
				end
				if (tbl_hi[i] > hi) begin
					nlo.push_back(hi + 64'sd1);
					nhi.push_back(tbl_hi[i]);
				end
			end
		end
		return commit_list(nlo, nhi);
	endfunction

	function automatic reply_t predict_reply(input command_t c);
		reply_t r;
		r = '0;
		if (c.cmd <= CMD_SET && c.hi < c.lo) begin
			r.status = ST_BAD;
		end else begin
			case (c.cmd)
				CMD_ADD: r.status = table_add(c.lo, c.hi);
				CMD_REMOVE: r.status = table_remove(c.lo, c.hi);
				CMD_QUERY: begin
					for (int i = 0; i < tbl_count; i++)
						if (tbl_lo[i] <= c.lo && tbl_hi[i] >= c.hi)
							r.covered = 1'b1;
				end
				CMD_SET: begin
					tbl_lo[0] = c.lo;
					tbl_hi[0] = c.hi;
					tbl_count = 1;
				end
				CMD_READ: begin
					if (c.idx < tbl_count) begin
						r.elo = tbl_lo[c.idx];
						r.ehi = tbl_hi[c.idx];
					end
				end
				default: ;
			endcase
		end
		r.total = tbl_count[5:0];
		return r;
	endfunction

	// values clustered so that ranges collide often
	function automatic logic signed [63:0] pick_bound();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return {$urandom, $urandom};
		if (sel == 1)
			return BOUND_MAX - $signed(64'($urandom_range(0, 3)));
		if (sel == 2)
			return -BOUND_MAX - 64'sd1 + $signed(64'($urandom_range(0, 3)));
		return $signed(64'($urandom_range(0, 600))) - 64'sd300;
	endfunction

	function automatic command_t make_cmd(input logic [2:0] op,
			input logic signed [63:0] lo, input logic signed [63:0] hi,
			input logic [4:0] idx);
		command_t c;
		c.cmd = op;
		c.lo = lo;
		c.hi = hi;
		c.idx = idx;
		return c;
	endfunction

	function automatic command_t random_cmd();
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] t;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		a = pick_bound();
		if ($urandom_range(0, 3) == 0)
			b = pick_bound();
		else
			b = a + $signed(64'($urandom_range(0, 12)));
		if (b < a && $urandom_range(0, 9) != 0) begin
			t = a;
			a = b;
			b = t;
		end
		if (sel < 40) return make_cmd(CMD_ADD, a, b, 5'($urandom));
		if (sel < 62) return make_cmd(CMD_REMOVE, a, b, 5'($urandom));
		if (sel < 80) return make_cmd(CMD_QUERY, a, b, 5'($urandom));
		if (sel < 82) return make_cmd(CMD_SET, a, b, 5'($urandom));
		if (sel < 97) return make_cmd(CMD_READ, a, b, 5'($urandom));
		return make_cmd(3'($urandom_range(5, 7)), a, b, 5'($urandom));
	endfunction

	initial begin
		logic signed [63:0] lo_min;
		lo_min = -BOUND_MAX - 64'sd1;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = '0;
		cmd_ch.range_low = '0;
		cmd_ch.range_high = '0;
		cmd_ch.entry_index = '0;
		reply_ch.ready = 1'b0;

		pending_cmds.push_back(make_cmd(CMD_READ, 64'sd0, 64'sd0, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_ADD, lo_min, lo_min + 64'sd5, 5'd31));
		pending_cmds.push_back(make_cmd(CMD_ADD, BOUND_MAX - 64'sd5, BOUND_MAX, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_ADD, BOUND_MAX, BOUND_MAX, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 64'sd10, 64'sd20, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 64'sd21, 64'sd25, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 64'sd30, 64'sd40, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 64'sd5, 64'sd35, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 64'sd9, 64'sd1, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_REMOVE, 64'sd15, 64'sd16, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_REMOVE, 64'sd3, 64'sd2, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 64'sd10, 64'sd14, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 64'sd14, 64'sd17, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_QUERY, BOUND_MAX, BOUND_MAX, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 64'sd5, 64'sd4, 5'd0));
		for (int i = 0; i < 5; i++)
			pending_cmds.push_back(make_cmd(CMD_READ, 64'sd0, 64'sd0, 5'(i)));
		pending_cmds.push_back(make_cmd(CMD_READ, 64'sd0, 64'sd0, 5'd31));
		pending_cmds.push_back(make_cmd(3'd7, -64'sd1, -64'sd1, 5'd31));
		pending_cmds.push_back(make_cmd(CMD_SET, 64'sd7, 64'sd6, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_SET, lo_min, BOUND_MAX, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_REMOVE, lo_min, BOUND_MAX, 5'd0));
		// fill the table with single points, then overflow it
		for (int i = 0; i < TABLE_DEPTH + 1; i++)
			pending_cmds.push_back(make_cmd(CMD_ADD, 64'(2 * i), 64'(2 * i), 5'd0));
		pending_cmds.push_back(make_cmd(CMD_REMOVE, 64'sd3, 64'sd3, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_READ, 64'sd0, 64'sd0, 5'd31));
		pending_cmds.push_back(make_cmd(CMD_SET, 64'sd0, 64'sd100, 5'd0));
		pending_cmds.push_back(make_cmd(CMD_QUERY, 64'sd50, 64'sd50, 5'd0));
		for (int i = 0; i < 17; i++)
			pending_cmds.push_back(make_cmd(CMD_REMOVE, 64'(3 * i + 1), 64'(3 * i + 1),
				5'd0));
		for (int i = 0; i < 1000; i++)
			pending_cmds.push_back(random_cmd());

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_replies.push_back(predict_reply(pending_cmds.pop_front()));
				sent++;
				send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
			end
			if (send_wait > 0 || pending_cmds.size() == 0) begin
				if (send_wait > 0) send_wait--;
				cmd_ch.valid <= 1'b0;
			end else begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.cmd <= pending_cmds[0].cmd;
				cmd_ch.range_low <= pending_cmds[0].lo;
				cmd_ch.range_high <= pending_cmds[0].hi;
				cmd_ch.entry_index <= pending_cmds[0].idx;
			end
			if (pending_cmds.size() == 0)
				stim_done = 1;
		end
	end

	// long receiver hold-off once in the random part
	always @(posedge clk) begin
		if (arst_n) begin
			if (received >= 300 && hold_cycles == 0)
				hold_cycles <= 400;
			else if (hold_cycles > 1)
				hold_cycles <= hold_cycles - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (reply_ch.valid && reply_ch.ready) begin
				reply_t exp_r;
				received++;
				if (expected_replies.size() == 0) begin
					$error("result transfer with no command outstanding");
					errors++;
				end else begin
					exp_r = expected_replies.pop_front();
					if (exp_r.status == ST_FULL) full_seen++;
					if (exp_r.status == ST_BAD) bad_seen++;
					if (exp_r.covered) hits_seen++;
					if (reply_ch.status !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, reply_ch.status);
						errors++;
					end
					if (reply_ch.covered !== exp_r.covered) begin
						$error("covered exp %0d got %0d", exp_r.covered, reply_ch.covered);
						errors++;
					end
					if (reply_ch.entry_low !== exp_r.elo) begin
						$error("entry_low exp %0d got %0d", exp_r.elo, reply_ch.entry_low);
						errors++;
					end
					if (reply_ch.entry_high !== exp_r.ehi) begin
						$error("entry_high exp %0d got %0d", exp_r.ehi, reply_ch.entry_high);
						errors++;
					end
					if (reply_ch.entry_total !== exp_r.total) begin
						$error("entry_total exp %0d got %0d", exp_r.total,
							reply_ch.entry_total);
						errors++;
					end
				end
				recv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
			end
			if (hold_cycles > 1) begin
				reply_ch.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				reply_ch.ready <= 1'b0;
			end else begin
				reply_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		wait (stim_done && expected_replies.size() == 0);
		repeat (50) @(posedge clk);
		$display("%0d commands, %0d results; %0d rejected full, %0d invalid, %0d covered",
			sent, received, full_seen, bad_seen, hits_seen);
		if (errors == 0 && expected_replies.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/ise_pkg.sv
sv/ise_in_if.sv
sv/ise_out_if.sv
sv/ise_cell.sv
sv/interval_set_engine.sv
sv/ise_checker.sv
dv/interval_set_engine_test.sv
